// ===== hdl/bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Button detector package
// Shared types and constants for the click / long-press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

    // Filter length of the debouncer, in ticks (1 to 255).
    localparam int unsigned DEBOUNCE_TICKS = 10;
    localparam int unsigned DEB_W          = 8;
    localparam int unsigned TICK_W         = 16;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned CFG_INDEX_W    = 2;

    localparam logic [DEB_W-1:0] DEB_LIMIT = DEB_W'(DEBOUNCE_TICKS);

    // Register values after reset.
    localparam logic              RST_ACTIVE_LEVEL = 1'b0;
    localparam logic [TICK_W-1:0] RST_CLICK_GAP    = 16'd200;
    localparam logic [TICK_W-1:0] RST_LONG_HOLD    = 16'd1000;
    localparam logic [TICK_W-1:0] RST_REPEAT       = 16'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_CLICK_GAP    = 2'd1,
        REG_LONG_HOLD    = 2'd2,
        REG_REPEAT       = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LONG   = 3'd3,
        EV_REPEAT = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_WAIT = 2'd2,
        PH_LONG = 2'd3
    } phase_t;

    typedef struct packed {
        logic              active_level;
        logic [TICK_W-1:0] click_gap_ticks;
        logic [TICK_W-1:0] long_hold_ticks;
        logic [TICK_W-1:0] repeat_ticks;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/button_click_long_press_detector.sv =====
// ----------------------------------------------------------------------------
// Button click / long-press detector
// Debounces a sampled button pin and classifies presses into click and
// long-press events, one event code per tick.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid/in_stall  | pin_level (1 bit)
//  out     | source    | out_valid/out_stall| event_code (3 bits)
//  cfg     | sink      | cfg_wr_en          | cfg_index (2), cfg_data (16)
//
//  Each input beat is one tick and yields exactly one output beat. While the
//  output side does not stall, one beat per clock is sustained; the tick
//  update is a single pass through the debouncer and the phase machine
//  between the input and result registers. A stall on the output holds the
//  result register; the input register still takes one more beat, then
//  in_stall rises until the result is taken. Reset clears the configuration
//  to its defaults and all filter and phase state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_long_press_detector
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire                              pin_level,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [2:0]                       event_code,
    input  wire                              cfg_wr_en,
    input  wire  [bcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [bcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcd_pkg::*;

    cfg_t   cfg_reg;
    logic   in_valid_reg;
    logic   pin_reg;
    logic   out_valid_reg;
    event_t event_reg;

    logic   tick_move;
    logic   raw_pressed;
    logic   pressed_next;
    event_t tick_event;

    // The tick in the input register is processed when the result register
    // is empty or is being emptied in this cycle.
    assign tick_move = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !tick_move;

    assign raw_pressed = (pin_reg == cfg_reg.active_level);

    // Configuration registers; bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level    <= RST_ACTIVE_LEVEL;
            cfg_reg.click_gap_ticks <= RST_CLICK_GAP;
            cfg_reg.long_hold_ticks <= RST_LONG_HOLD;
            cfg_reg.repeat_ticks    <= RST_REPEAT;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ACTIVE_LEVEL: cfg_reg.active_level    <= cfg_data[0];
                REG_CLICK_GAP:    cfg_reg.click_gap_ticks <= cfg_data[TICK_W-1:0];
                REG_LONG_HOLD:    cfg_reg.long_hold_ticks <= cfg_data[TICK_W-1:0];
                REG_REPEAT:       cfg_reg.repeat_ticks    <= cfg_data[TICK_W-1:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (tick_move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pin_reg <= pin_level;
        end
    end

    bcd_debounce u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_en      (tick_move),
        .raw_pressed  (raw_pressed),
        .pressed_next (pressed_next)
    );

    bcd_phase_fsm u_phase
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (tick_move),
        .pressed   (pressed_next),
        .cfg       (cfg_reg),
        .event_out (tick_event)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_move)
        begin
            event_reg <= tick_event;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

endmodule

`default_nettype wire

// ===== hdl/bcd_debounce.sv =====
// ----------------------------------------------------------------------------
// Button detector debouncer
// Run-length filter on the raw pressed bit, updated once per processed tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_debounce
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  tick_en,
    input  wire  raw_pressed,
    output logic pressed_next
);
    import bcd_pkg::*;

    logic [DEB_W-1:0] count_reg;
    logic [DEB_W-1:0] count_next;
    logic             filtered_reg;
    logic [DEB_W-1:0] count_inc;

    assign count_inc = count_reg + DEB_W'(1);

    always_comb
    begin
        count_next   = '0;
        pressed_next = filtered_reg;
        if (raw_pressed != filtered_reg)
        begin
            if (count_inc >= DEB_LIMIT)
            begin
                pressed_next = raw_pressed;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            filtered_reg <= 1'b0;
        end
        else if (tick_en)
        begin
            count_reg    <= count_next;
            filtered_reg <= pressed_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bcd_phase_fsm.sv =====
// ----------------------------------------------------------------------------
// Button detector phase machine
// Idle / hold / wait-for-click / long-press sequencer with tick timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_phase_fsm
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           tick_en,
    input  wire           pressed,
    input  wire bcd_pkg::cfg_t cfg,
    output bcd_pkg::event_t event_out
);
    import bcd_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [1:0]        clicks_reg;
    logic [1:0]        clicks_next;
    logic [TICK_W-1:0] tick_bump;

    // The counter saturates at its top value.
    assign tick_bump = (tick_reg == {TICK_W{1'b1}}) ? tick_reg : tick_reg + TICK_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        clicks_next = clicks_reg;
        event_out   = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_HOLD;
                    tick_next  = '0;
                end
            end
            PH_HOLD:
            begin
                if (pressed)
                begin
                    tick_next = tick_bump;
                    if (tick_bump >= cfg.long_hold_ticks)
                    begin
                        event_out  = EV_LONG;
                        phase_next = PH_LONG;
                        tick_next  = '0;
                    end
                end
                else
                begin
                    if (clicks_reg != 2'd3)
                    begin
                        clicks_next = clicks_reg + 2'd1;
                    end
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
            end
            PH_WAIT:
            begin
                if (pressed)
                begin
                    phase_next = PH_HOLD;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_bump;
                    if (tick_bump >= cfg.click_gap_ticks)
                    begin
                        if (clicks_reg == 2'd1)
                        begin
                            event_out = EV_SINGLE;
                        end
                        else if (clicks_reg == 2'd2)
                        begin
                            event_out = EV_DOUBLE;
                        end
                        phase_next  = PH_IDLE;
                        tick_next   = '0;
                        clicks_next = '0;
                    end
                end
            end
            PH_LONG:
            begin
                if (pressed)
                begin
                    tick_next = tick_bump;
                    if (tick_bump >= cfg.repeat_ticks)
                    begin
                        event_out = EV_REPEAT;
                        tick_next = '0;
                    end
                end
                else
                begin
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                    clicks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            clicks_reg <= '0;
        end
        else if (tick_en)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            clicks_reg <= clicks_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bcd_checker.sv =====
// ----------------------------------------------------------------------------
// Button detector port checker
// Concurrent checks on the detector's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_checker
(
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_stall,
    input wire                              out_valid,
    input wire                              out_stall,
    input wire [2:0]                        event_code
);
    import bcd_pkg::*;

    // A delivered beat always carries a defined event code.
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code == EV_NONE || event_code == EV_SINGLE ||
                       event_code == EV_DOUBLE || event_code == EV_LONG ||
                       event_code == EV_REPEAT))
        else $error("event code out of range");

    // Input back-pressure only comes from a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_stall || !out_valid) |-> !in_stall)
        else $error("input stalled while output is free");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(event_code)))
        else $error("stalled result changed");

    // Without a beat in flight nothing can come out.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !in_stall && !$past(in_valid) && !in_valid) |=> ##1 !out_valid)
        else $error("result without an accepted beat");

endmodule

bind button_click_long_press_detector bcd_checker u_bcd_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Button detector testbench
// Drives sampled pin levels through the click / long-press detector under
// random input gaps and output stalls. Every tick is predicted by a local
// model of the debouncer and phase machine and checked beat for beat.
// ----------------------------------------------------------------------------

module tb_top;

    import bcd_pkg::*;

    // Generous upper bound on the whole run, in clock cycles.
    localparam int unsigned TIMEOUT_CYCLES = 200000;
    // Cycles to let pass after the last result before a register write or the end.
    localparam int unsigned SETTLE_CYCLES  = 6;
    // Accepted ticks after which the receiver holds off for a long stretch.
    localparam int unsigned HOLDOFF_AT     = 1200;
    localparam int unsigned HOLDOFF_LEN    = 160;
    // Cap on printed mismatch lines.
    localparam int unsigned MAX_REPORTS    = 20;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   pin_level = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2:0]             event_code;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ACTIVE_LEVEL;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    button_click_long_press_detector dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pin_level  (pin_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_code (event_code),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // The clock period is 12 time units.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Local copy of the detector: the register values and the filter and
    // phase state, advanced once per accepted input beat.
    // ------------------------------------------------------------------------
    cfg_t              cfg;
    logic [DEB_W-1:0]  deb_cnt;
    logic              filt_pressed;
    phase_t            ph;
    logic [TICK_W-1:0] ticks;
    logic [1:0]        clicks;

    // Pin samples waiting to be offered, and event codes waiting to come out.
    logic              pin_samples[$];
    event_t            events_due[$];

    int unsigned       ticks_sent;
    int unsigned       ticks_checked;
    int unsigned       failures;
    int unsigned       settings_run;
    int unsigned       ev_seen[5];

    // Advances the local state by one tick and returns the event it causes.
    function automatic event_t predict_event(logic level);
        logic   pressed;
        event_t ev;
        pressed = (level == cfg.active_level);
        ev      = EV_NONE;

        // The debouncer needs DEBOUNCE_TICKS disagreeing samples in a row;
        // any agreeing sample starts the count over.
        if (pressed != filt_pressed)
        begin
            deb_cnt = deb_cnt + 1'b1;
            if (deb_cnt >= DEB_LIMIT)
            begin
                deb_cnt      = '0;
                filt_pressed = pressed;
            end
        end
        else
        begin
            deb_cnt = '0;
        end

        // The tick counter saturates rather than wraps; the comparison uses
        // the value after the increment, so a zero timeout fires at once.
        case (ph)
            PH_IDLE:
            begin
                if (filt_pressed)
                begin
                    ph    = PH_HOLD;
                    ticks = '0;
                end
            end
            PH_HOLD:
            begin
                if (filt_pressed)
                begin
                    if (ticks != '1)
                        ticks = ticks + 1'b1;
                    if (ticks >= cfg.long_hold_ticks)
                    begin
                        ev    = EV_LONG;
                        ph    = PH_LONG;
                        ticks = '0;
                    end
                end
                else
                begin
                    // The click count sticks at three.
                    if (clicks != 2'd3)
                        clicks = clicks + 1'b1;
                    ph    = PH_WAIT;
                    ticks = '0;
                end
            end
            PH_WAIT:
            begin
                if (filt_pressed)
                begin
                    ph    = PH_HOLD;
                    ticks = '0;
                end
                else
                begin
                    if (ticks != '1)
                        ticks = ticks + 1'b1;
                    if (ticks >= cfg.click_gap_ticks)
                    begin
                        // Three or more clicks end the sequence silently.
                        if (clicks == 2'd1)
                            ev = EV_SINGLE;
                        else if (clicks == 2'd2)
                            ev = EV_DOUBLE;
                        ph     = PH_IDLE;
                        ticks  = '0;
                        clicks = '0;
                    end
                end
            end
            default:
            begin
                if (filt_pressed)
                begin
                    if (ticks != '1)
                        ticks = ticks + 1'b1;
                    if (ticks >= cfg.repeat_ticks)
                    begin
                        ev    = EV_REPEAT;
                        ticks = '0;
                    end
                end
                else
                begin
                    ph     = PH_IDLE;
                    ticks  = '0;
                    clicks = '0;
                end
            end
        endcase
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. Beats are offered in bursts of random length separated by
    // random gaps; now and then a long burst with no gap at all. A stalled
    // beat is held unchanged. Each accepted beat is run through the local
    // model and its event code is queued.
    // ------------------------------------------------------------------------
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            pin_level  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                events_due.push_back(predict_event(pin_level));
                ticks_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pin_samples.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    pin_level <= pin_samples.pop_front();
                    if (burst_left != 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall. It switches among four patterns, each held for a random
    // stretch: never, light random, periodic, and heavy random. Once, after
    // enough ticks have gone in, it holds off for a long stretch so that the
    // detector fills up and stalls its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    int unsigned stall_mode;
    int unsigned mode_left;
    int unsigned holdoff_left;
    bit          holdoff_done;
    int unsigned stall_cyc;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_mode   = 0;
            mode_left    = 0;
            holdoff_left = 0;
            holdoff_done = 1'b0;
            stall_cyc    = 0;
        end
        else
        begin
            stall_cyc++;
            if (!holdoff_done && ticks_sent >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            else
            begin
                mode_left--;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ((stall_cyc % 5) < 2);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every accepted output beat is matched against the oldest
    // queued event code.
    // ------------------------------------------------------------------------
    event_t exp_ev;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (events_due.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected output beat, expected none, got %0d",
                             $time, event_code);
            end
            else
            begin
                exp_ev = events_due.pop_front();
                ticks_checked++;
                if (event_code !== exp_ev)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: event_code mismatch, expected %0d, got %0d",
                                 $time, exp_ev, event_code);
                end
                if (event_code <= 3'd4)
                    ev_seen[event_code]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Queues len ticks at one logical button state.
    task automatic push_run(logic pressed, int unsigned len);
        repeat (len)
            pin_samples.push_back(pressed ? cfg.active_level : ~cfg.active_level);
    endtask

    // Queues at least count ticks of gestures shaped around the current
    // timeouts: click sequences of one to four presses, long presses with
    // repeats, and bursts of bounce noise in runs of one to twelve ticks.
    task automatic push_gestures(int unsigned count);
        int unsigned target;
        int unsigned gap_span;
        int unsigned hold_span;
        int unsigned rep_span;
        int unsigned kind;
        int unsigned n_clicks;
        target    = pin_samples.size() + count;
        gap_span  = (cfg.click_gap_ticks > 40) ? 40 : cfg.click_gap_ticks;
        hold_span = (cfg.long_hold_ticks > 50) ? 50 : cfg.long_hold_ticks;
        rep_span  = (cfg.repeat_ticks > 20) ? 20 : cfg.repeat_ticks;
        while (pin_samples.size() < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                repeat ($urandom_range(1, 6))
                    push_run(1'($urandom_range(0, 1)), $urandom_range(1, 12));
            end
            else if (kind < 35)
            begin
                push_run(1'b1, 10 + hold_span + $urandom_range(0, 3 * rep_span + 6));
                push_run(1'b0, 12 + gap_span + $urandom_range(0, 4));
            end
            else
            begin
                n_clicks = $urandom_range(1, 4);
                for (int unsigned i = 0; i < n_clicks; i++)
                begin
                    push_run(1'b1, $urandom_range(8, 12 + hold_span));
                    if (i + 1 < n_clicks)
                        push_run(1'b0, $urandom_range(8, 12 + gap_span));
                end
                push_run(1'b0, 12 + gap_span + $urandom_range(0, 6));
            end
        end
    endtask

    // Waits until every queued tick has gone in and every event has come
    // out, then lets the pipeline settle.
    task automatic wait_drained();
        while (pin_samples.size() != 0 || in_valid || events_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        // Bits above a register's width are dropped.
        case (idx)
            REG_ACTIVE_LEVEL: cfg.active_level    = data[0];
            REG_CLICK_GAP:    cfg.click_gap_ticks = data;
            REG_LONG_HOLD:    cfg.long_hold_ticks = data;
            default:          cfg.repeat_ticks    = data;
        endcase
    endtask

    // Waits for the detector to drain, writes all four registers, and queues
    // at least count ticks of gestures. The active level is written with
    // random upper bits, which the detector must ignore.
    task automatic run_setting(logic act, logic [TICK_W-1:0] gap, logic [TICK_W-1:0] hold,
                               logic [TICK_W-1:0] rep, int unsigned count);
        wait_drained();
        write_reg(REG_ACTIVE_LEVEL, {15'($urandom), act});
        write_reg(REG_CLICK_GAP, gap);
        write_reg(REG_LONG_HOLD, hold);
        write_reg(REG_REPEAT, rep);
        @(negedge clk);
        push_gestures(count);
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. Between settings the driver has nothing to send until
    // every expected event has come out, so the sender pauses fully at each
    // boundary.
    // ------------------------------------------------------------------------
    initial
    begin
        cfg.active_level    = RST_ACTIVE_LEVEL;
        cfg.click_gap_ticks = RST_CLICK_GAP;
        cfg.long_hold_ticks = RST_LONG_HOLD;
        cfg.repeat_ticks    = RST_REPEAT;
        deb_cnt       = '0;
        filt_pressed  = 1'b0;
        ph            = PH_IDLE;
        ticks         = '0;
        clicks        = '0;
        ticks_sent    = 0;
        ticks_checked = 0;
        failures      = 0;
        settings_run  = 0;
        foreach (ev_seen[i])
            ev_seen[i] = 0;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // Directed part with all timeouts at zero and the active level high.
        // Short bounces must not move the filter; a steady press gives a
        // long press on the first counted tick and then a repeat on every
        // tick; the release returns the machine to idle.
        run_setting(1'b1, '0, '0, '0, 0);
        push_run(1'b1, 2);
        push_run(1'b0, 1);
        push_run(1'b1, 12);
        push_run(1'b0, 10);

        // Random part over several settings, from the reset defaults and
        // full-scale timeouts down to zero and one.
        run_setting(1'b0, RST_CLICK_GAP, RST_LONG_HOLD, RST_REPEAT, 120);
        run_setting(1'b1, 16'd20, 16'd40, 16'd8, 300);
        run_setting(1'b0, 16'd0, 16'd0, 16'd0, 180);
        run_setting(1'b1, 16'd1, 16'd1, 16'd1, 150);
        run_setting(1'b0, 16'd6, 16'd25, 16'd3, 300);
        run_setting(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 120);
        run_setting(1'($urandom_range(0, 1)), 16'($urandom_range(0, 30)),
                    16'($urandom_range(0, 50)), 16'($urandom_range(0, 15)), 180);

        wait_drained();
        if (events_due.size() != 0)
            failures++;

        $display("Ran %0d ticks over %0d register settings, with zero and full-scale timeouts,",
                 ticks_checked, settings_run);
        $display("random stalls and one long hold-off; single %0d, double %0d, long %0d, repeat %0d.",
                 ev_seen[EV_SINGLE], ev_seen[EV_DOUBLE], ev_seen[EV_LONG], ev_seen[EV_REPEAT]);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * 12);
        $display("Timeout with %0d events still due.", events_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bcd_pkg.sv
hdl/bcd_debounce.sv
hdl/bcd_phase_fsm.sv
hdl/button_click_long_press_detector.sv
hdl/bcd_checker.sv
dv/tb_top.sv
